/* src/assert_macros.svh */
// assert_macros.svh: assertion macros for the terrain texture blend block.
// No dependencies; expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HSTB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hstb_pkg.sv */
// hstb_pkg: shared types, register indexes and weight ROMs for the
// height/slope texture blend pipeline. No dependencies.
package hstb_pkg;

  localparam int WEIGHT_FRAC_BITS_DEF = 8;
  localparam int ROM_BITS             = 16;
  localparam int HEIGHT_W             = 8;
  localparam int CHAN_W               = 8;
  localparam int NCHAN                = 3;
  localparam int TEXEL_W              = CHAN_W * NCHAN;
  localparam int CFG_ADDR_W           = 5;
  localparam int CFG_DATA_W           = 32;
  localparam int SQ_W                 = 16;
  localparam int DIST_W               = 6;

  localparam logic [2:0] REG_BAND_LIMIT_1       = 3'd0;
  localparam logic [2:0] REG_BAND_LIMIT_2       = 3'd1;
  localparam logic [2:0] REG_BAND_LIMIT_3       = 3'd2;
  localparam logic [2:0] REG_HEIGHT_BLEND_WIDTH = 3'd3;
  localparam logic [2:0] REG_SLOPE_BLEND_START  = 3'd4;
  localparam logic [2:0] REG_SLOPE_FULL_START   = 3'd5;

  localparam logic [7:0] RST_BAND_LIMIT_1       = 8'd64;
  localparam logic [7:0] RST_BAND_LIMIT_2       = 8'd102;
  localparam logic [7:0] RST_BAND_LIMIT_3       = 8'd205;
  localparam logic [4:0] RST_HEIGHT_BLEND_WIDTH = 5'd13;
  localparam logic [7:0] RST_SLOPE_BLEND_START  = 8'd122;
  localparam logic [7:0] RST_SLOPE_FULL_START   = 8'd214;

  typedef logic [TEXEL_W-1:0]  texel_t;
  typedef logic [ROM_BITS-1:0] rom_word_t;

  typedef struct packed {
    logic [7:0] band_limit_1;
    logic [7:0] band_limit_2;
    logic [7:0] band_limit_3;
    logic [4:0] height_blend_width;
    logic [7:0] slope_blend_start;
    logic [7:0] slope_full_start;
  } hstb_cfg_t;

  typedef struct packed {
    logic              solid;
    logic [DIST_W-1:0] hdist;
    texel_t            tex_x;
    texel_t            tex_y;
    texel_t            tex_cliff;
    logic [SQ_W-1:0]   dx_sq;
    logic [SQ_W-1:0]   dy_sq;
  } hstb_front_t;

  // sigmoid of height distance, 16-bit fraction
  localparam rom_word_t HEIGHT_ROM [32] = '{
    16'd32768, 16'd28630, 16'd24622, 16'd20858, 16'd17425, 16'd14375, 16'd11728, 16'd9479,
    16'd7600,  16'd6053,  16'd4795,  16'd3782,  16'd2972,  16'd2329,  16'd1822,  16'd1422,
    16'd1109,  16'd863,   16'd672,   16'd522,   16'd406,   16'd315,   16'd245,   16'd190,
    16'd148,   16'd115,   16'd89,    16'd69,    16'd54,    16'd42,    16'd32,    16'd25
  };

  // cliff weight per squared-gradient bucket of 8, 16-bit fraction
  localparam rom_word_t SLOPE_ROM [32] = '{
    16'd271,   16'd398,   16'd569,   16'd793,   16'd1082,  16'd1446,  16'd1897,  16'd2445,
    16'd3103,  16'd3879,  16'd4780,  16'd5814,  16'd6982,  16'd8284,  16'd9718,  16'd11276,
    16'd12948, 16'd14721, 16'd16580, 16'd18507, 16'd20485, 16'd22494, 16'd24516, 16'd26532,
    16'd28528, 16'd30488, 16'd32399, 16'd34251, 16'd36037, 16'd37749, 16'd39384, 16'd40938
  };

endpackage

/* src/hstb_front.sv */
// hstb_front: first two pipeline stages - band select, gradient deltas,
// then edge-zone decision, clamped distance, texel pick and squares.
// Depends on hstb_pkg.
module hstb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [hstb_pkg::HEIGHT_W-1:0] height_here,
  input  logic [hstb_pkg::HEIGHT_W-1:0] height_east,
  input  logic [hstb_pkg::HEIGHT_W-1:0] height_west,
  input  logic [hstb_pkg::HEIGHT_W-1:0] height_south,
  input  logic [hstb_pkg::HEIGHT_W-1:0] height_north,
  input  hstb_pkg::texel_t              tex_band0,
  input  hstb_pkg::texel_t              tex_band1,
  input  hstb_pkg::texel_t              tex_band2,
  input  hstb_pkg::texel_t              tex_band3,
  input  hstb_pkg::texel_t              tex_cliff,
  input  hstb_pkg::hstb_cfg_t           cfg,
  output logic                          front_valid,
  output hstb_pkg::hstb_front_t         front
);
  import hstb_pkg::*;

  localparam int NTEX = 5;

  // stage 1
  logic                s1_valid_r;
  logic [HEIGHT_W-1:0] s1_h_r;
  logic [1:0]          s1_band_r;
  texel_t              s1_tex_r [NTEX];
  logic signed [8:0]   s1_dx_r;
  logic signed [8:0]   s1_dy_r;
  logic [1:0]          band_nxt;
  logic signed [8:0]   dx_nxt;
  logic signed [8:0]   dy_nxt;

  // stage 2
  logic                s2_valid_r;
  hstb_front_t         s2_r;
  hstb_front_t         s2_nxt;

  logic signed [10:0]  h_s;
  logic signed [10:0]  w_s;
  logic signed [10:0]  lo_s;
  logic signed [10:0]  hi_s;
  logic signed [10:0]  d_full;
  logic                solid;
  logic                lower;
  logic [2:0]          idx_here;
  logic [2:0]          idx_up;
  logic [2:0]          idx_dn;
  logic signed [17:0]  dx_prod;
  logic signed [17:0]  dy_prod;

  always_comb begin
    if (height_here <= cfg.band_limit_1) begin
      band_nxt = 2'd0;
    end else if (height_here >= cfg.band_limit_1 && height_here <= cfg.band_limit_2) begin
      band_nxt = 2'd1;
    end else if (height_here >= cfg.band_limit_2 && height_here <= cfg.band_limit_3) begin
      band_nxt = 2'd2;
    end else begin
      band_nxt = 2'd3;
    end
    dx_nxt = $signed({1'b0, height_east}) - $signed({1'b0, height_west});
    dy_nxt = $signed({1'b0, height_south}) - $signed({1'b0, height_north});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_h_r      <= height_here;
    s1_band_r   <= band_nxt;
    s1_dx_r     <= dx_nxt;
    s1_dy_r     <= dy_nxt;
    s1_tex_r[0] <= tex_band0;
    s1_tex_r[1] <= tex_band1;
    s1_tex_r[2] <= tex_band2;
    s1_tex_r[3] <= tex_band3;
    s1_tex_r[4] <= tex_cliff;
  end

  assign dx_prod = 18'(s1_dx_r) * 18'(s1_dx_r);
  assign dy_prod = 18'(s1_dy_r) * 18'(s1_dy_r);

  always_comb begin
    h_s = $signed({3'b000, s1_h_r});
    w_s = $signed({6'b000000, cfg.height_blend_width});
    case (s1_band_r)
      2'd0: begin
        lo_s = 11'sd0;
        hi_s = $signed({3'b000, cfg.band_limit_1});
      end
      2'd1: begin
        lo_s = $signed({3'b000, cfg.band_limit_1});
        hi_s = $signed({3'b000, cfg.band_limit_2});
      end
      2'd2: begin
        lo_s = $signed({3'b000, cfg.band_limit_2});
        hi_s = $signed({3'b000, cfg.band_limit_3});
      end
      default: begin
        lo_s = $signed({3'b000, cfg.band_limit_3});
        hi_s = 11'sd256;
      end
    endcase

    solid = (s1_band_r == 2'd0 && h_s <= hi_s - w_s) ||
            (s1_band_r == 2'd3 && h_s >= lo_s + w_s) ||
            (h_s >= lo_s + w_s && h_s <= hi_s - w_s);
    lower = !solid && s1_band_r != 2'd0 && h_s <= lo_s + w_s;

    d_full = lower ? (h_s - lo_s) : (h_s - hi_s);

    idx_here = {1'b0, s1_band_r};
    idx_up   = idx_here + 3'd1;
    idx_dn   = {1'b0, s1_band_r - 2'd1};

    s2_nxt.solid = solid;
    if (d_full > 11'sd31) begin
      s2_nxt.hdist = 6'sd31;
    end else if (d_full < -11'sd31) begin
      s2_nxt.hdist = -6'sd31;
    end else begin
      s2_nxt.hdist = d_full[DIST_W-1:0];
    end
    if (solid) begin
      s2_nxt.tex_x = s1_tex_r[idx_here];
      s2_nxt.tex_y = s1_tex_r[idx_here];
    end else if (lower) begin
      s2_nxt.tex_x = s1_tex_r[idx_here];
      s2_nxt.tex_y = s1_tex_r[idx_dn];
    end else begin
      s2_nxt.tex_x = s1_tex_r[idx_up];
      s2_nxt.tex_y = s1_tex_r[idx_here];
    end
    s2_nxt.tex_cliff = s1_tex_r[4];
    s2_nxt.dx_sq     = dx_prod[SQ_W-1:0];
    s2_nxt.dy_sq     = dy_prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  assign front_valid = s2_valid_r;
  assign front       = s2_r;

endmodule

/* src/hstb_weight.sv */
// hstb_weight: third pipeline stage - height and slope weight ROM lookups,
// rounding to the weight fraction, gradient saturation and cliff decision.
// Depends on hstb_pkg.
module hstb_weight #(
  parameter int WEIGHT_FRAC_BITS = hstb_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      front_valid,
  input  hstb_pkg::hstb_front_t     front,
  input  hstb_pkg::hstb_cfg_t       cfg,
  output logic                      wt_valid,
  output logic [WEIGHT_FRAC_BITS:0] wt_height,
  output logic [WEIGHT_FRAC_BITS:0] wt_slope,
  output hstb_pkg::texel_t          wt_tex_x,
  output hstb_pkg::texel_t          wt_tex_y,
  output hstb_pkg::texel_t          wt_tex_cliff
);
  import hstb_pkg::*;

  localparam int WB = WEIGHT_FRAC_BITS + 1;
  localparam int VW = ROM_BITS + 1;
  localparam int SH = ROM_BITS - WEIGHT_FRAC_BITS;
  localparam logic [VW-1:0] HALF = VW'(1) << (SH - 1);
  localparam logic [VW-1:0] FULL = VW'(1) << ROM_BITS;
  localparam logic [WB-1:0] ONE  = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  function automatic logic [WB-1:0] to_frac(input logic [VW-1:0] v);
    logic [VW-1:0] t;
    t = v + HALF;
    return t[VW-1:SH];
  endfunction

  logic          valid_r;
  logic [WB-1:0] wh_r;
  logic [WB-1:0] ws_r;
  texel_t        tex_x_r;
  texel_t        tex_y_r;
  texel_t        tex_cliff_r;

  logic [WB-1:0] wh_nxt;
  logic [WB-1:0] ws_nxt;
  logic [4:0]    mag;
  logic [VW-1:0] hv;
  logic [SQ_W:0] s_sum;
  logic [7:0]    s_sat;
  logic [WB-1:0] ws_rom;

  always_comb begin
    mag = front.hdist[DIST_W-1] ? 5'(6'd0 - front.hdist) : front.hdist[4:0];
    if (front.hdist[DIST_W-1]) begin
      hv = FULL - {1'b0, HEIGHT_ROM[mag]};
    end else begin
      hv = {1'b0, HEIGHT_ROM[mag]};
    end
    wh_nxt = front.solid ? '0 : to_frac(hv);

    s_sum  = {1'b0, front.dx_sq} + {1'b0, front.dy_sq};
    s_sat  = (|s_sum[SQ_W:8]) ? 8'hFF : s_sum[7:0];
    ws_rom = to_frac({1'b0, SLOPE_ROM[s_sat[7:3]]});
    if (s_sat >= cfg.slope_full_start) begin
      ws_nxt = ONE;
    end else if (s_sat >= cfg.slope_blend_start) begin
      ws_nxt = ws_rom;
    end else begin
      ws_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    wh_r        <= wh_nxt;
    ws_r        <= ws_nxt;
    tex_x_r     <= front.tex_x;
    tex_y_r     <= front.tex_y;
    tex_cliff_r <= front.tex_cliff;
  end

  assign wt_valid     = valid_r;
  assign wt_height    = wh_r;
  assign wt_slope     = ws_r;
  assign wt_tex_x     = tex_x_r;
  assign wt_tex_y     = tex_y_r;
  assign wt_tex_cliff = tex_cliff_r;

endmodule

/* src/hstb_blend.sv */
// hstb_blend: one registered per-channel blend stage,
// color = (x*(ONE-w) + y*w) >> WEIGHT_FRAC_BITS, truncated. Depends on hstb_pkg.
module hstb_blend #(
  parameter int WEIGHT_FRAC_BITS = hstb_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  hstb_pkg::texel_t          tex_x,
  input  hstb_pkg::texel_t          tex_y,
  input  logic [WEIGHT_FRAC_BITS:0] weight,
  output logic                      out_valid,
  output hstb_pkg::texel_t          color
);
  import hstb_pkg::*;

  localparam int WB = WEIGHT_FRAC_BITS + 1;
  localparam int PW = CHAN_W + WB + 1;
  localparam logic [WB-1:0] ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  logic          valid_r;
  texel_t        color_r;
  texel_t        color_nxt;
  logic [WB-1:0] w_inv;

  assign w_inv = ONE - weight;

  for (genvar c = 0; c < NCHAN; c++) begin : g_chan
    logic [PW-1:0] sum;
    assign sum = PW'(tex_x[c*CHAN_W +: CHAN_W]) * PW'(w_inv) +
                 PW'(tex_y[c*CHAN_W +: CHAN_W]) * PW'(weight);
    assign color_nxt[c*CHAN_W +: CHAN_W] = sum[WEIGHT_FRAC_BITS +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign out_valid = valid_r;
  assign color     = color_r;

endmodule

/* src/height_slope_texture_blend.sv */
// height_slope_texture_blend: takes one terrain pixel per clock (start while
// busy is low; busy never rises) and later returns its color as a one-cycle
// out_valid strobe with out_pixel_color; the receiver cannot stall, and the
// five-stage pipeline (band select, zone/distance and gradient squares,
// weight ROMs, height blend, cliff blend) sets the latency.
// Band and slope registers sit on an APB-style port; the user must write them
// only while no pixel is in flight, which the block itself does not enforce.
// Depends on hstb_pkg, hstb_front, hstb_weight, hstb_blend, assert_macros.svh.
`include "assert_macros.svh"

module height_slope_texture_blend #(
  parameter int WEIGHT_FRAC_BITS = hstb_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hstb_pkg::HEIGHT_W-1:0]   in_height_here,
  input  logic [hstb_pkg::HEIGHT_W-1:0]   in_height_east,
  input  logic [hstb_pkg::HEIGHT_W-1:0]   in_height_west,
  input  logic [hstb_pkg::HEIGHT_W-1:0]   in_height_south,
  input  logic [hstb_pkg::HEIGHT_W-1:0]   in_height_north,
  input  hstb_pkg::texel_t                in_texel_band0,
  input  hstb_pkg::texel_t                in_texel_band1,
  input  hstb_pkg::texel_t                in_texel_band2,
  input  hstb_pkg::texel_t                in_texel_band3,
  input  hstb_pkg::texel_t                in_texel_cliff,
  output logic                            out_valid,
  output hstb_pkg::texel_t                out_pixel_color,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hstb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hstb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hstb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import hstb_pkg::*;

  localparam int WB      = WEIGHT_FRAC_BITS + 1;
  localparam int LATENCY = 5;
  localparam logic [WB-1:0] ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  logic [7:0] cfg_band_limit_1_r;
  logic [7:0] cfg_band_limit_2_r;
  logic [7:0] cfg_band_limit_3_r;
  logic [4:0] cfg_height_blend_width_r;
  logic [7:0] cfg_slope_blend_start_r;
  logic [7:0] cfg_slope_full_start_r;

  hstb_cfg_t   cfg;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;
  logic        in_accept;

  logic        front_valid;
  hstb_front_t front;

  logic          wt_valid;
  logic [WB-1:0] wt_height;
  logic [WB-1:0] wt_slope;
  texel_t        wt_tex_x;
  texel_t        wt_tex_y;
  texel_t        wt_tex_cliff;

  logic          hb_valid;
  texel_t        hb_color;
  texel_t        hb_cliff_r;
  logic [WB-1:0] hb_slope_r;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign in_accept = start && !busy;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_band_limit_1_r       <= RST_BAND_LIMIT_1;
      cfg_band_limit_2_r       <= RST_BAND_LIMIT_2;
      cfg_band_limit_3_r       <= RST_BAND_LIMIT_3;
      cfg_height_blend_width_r <= RST_HEIGHT_BLEND_WIDTH;
      cfg_slope_blend_start_r  <= RST_SLOPE_BLEND_START;
      cfg_slope_full_start_r   <= RST_SLOPE_FULL_START;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BAND_LIMIT_1:       cfg_band_limit_1_r       <= pwdata[7:0];
        REG_BAND_LIMIT_2:       cfg_band_limit_2_r       <= pwdata[7:0];
        REG_BAND_LIMIT_3:       cfg_band_limit_3_r       <= pwdata[7:0];
        REG_HEIGHT_BLEND_WIDTH: cfg_height_blend_width_r <= pwdata[4:0];
        REG_SLOPE_BLEND_START:  cfg_slope_blend_start_r  <= pwdata[7:0];
        REG_SLOPE_FULL_START:   cfg_slope_full_start_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BAND_LIMIT_1:       prdata = CFG_DATA_W'(cfg_band_limit_1_r);
      REG_BAND_LIMIT_2:       prdata = CFG_DATA_W'(cfg_band_limit_2_r);
      REG_BAND_LIMIT_3:       prdata = CFG_DATA_W'(cfg_band_limit_3_r);
      REG_HEIGHT_BLEND_WIDTH: prdata = CFG_DATA_W'(cfg_height_blend_width_r);
      REG_SLOPE_BLEND_START:  prdata = CFG_DATA_W'(cfg_slope_blend_start_r);
      REG_SLOPE_FULL_START:   prdata = CFG_DATA_W'(cfg_slope_full_start_r);
      default:                prdata = '0;
    endcase
  end

  assign cfg.band_limit_1       = cfg_band_limit_1_r;
  assign cfg.band_limit_2       = cfg_band_limit_2_r;
  assign cfg.band_limit_3       = cfg_band_limit_3_r;
  assign cfg.height_blend_width = cfg_height_blend_width_r;
  assign cfg.slope_blend_start  = cfg_slope_blend_start_r;
  assign cfg.slope_full_start   = cfg_slope_full_start_r;

  hstb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_accept),
    .height_here  (in_height_here),
    .height_east  (in_height_east),
    .height_west  (in_height_west),
    .height_south (in_height_south),
    .height_north (in_height_north),
    .tex_band0    (in_texel_band0),
    .tex_band1    (in_texel_band1),
    .tex_band2    (in_texel_band2),
    .tex_band3    (in_texel_band3),
    .tex_cliff    (in_texel_cliff),
    .cfg          (cfg),
    .front_valid  (front_valid),
    .front        (front)
  );

  hstb_weight #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_weight (
    .clk          (clk),
    .rst_n        (rst_n),
    .front_valid  (front_valid),
    .front        (front),
    .cfg          (cfg),
    .wt_valid     (wt_valid),
    .wt_height    (wt_height),
    .wt_slope     (wt_slope),
    .wt_tex_x     (wt_tex_x),
    .wt_tex_y     (wt_tex_y),
    .wt_tex_cliff (wt_tex_cliff)
  );

  hstb_blend #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_blend_height (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wt_valid),
    .tex_x     (wt_tex_x),
    .tex_y     (wt_tex_y),
    .weight    (wt_height),
    .out_valid (hb_valid),
    .color     (hb_color)
  );

  // cliff texel and slope weight ride alongside the height blend
  always_ff @(posedge clk) begin
    hb_cliff_r <= wt_tex_cliff;
    hb_slope_r <= wt_slope;
  end

  hstb_blend #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_blend_slope (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hb_valid),
    .tex_x     (hb_color),
    .tex_y     (hb_cliff_r),
    .weight    (hb_slope_r),
    .out_valid (out_valid),
    .color     (out_pixel_color)
  );

  `HSTB_ASSERT_IMPLY(a_result_has_item, out_valid, $past(in_accept, LATENCY), "result without item")
  `HSTB_ASSERT_NEXT(a_solid_zero_weight, front_valid && front.solid, wt_height == '0, "solid band weight")
  `HSTB_ASSERT_NEXT(a_full_slope_cliff, wt_valid && wt_slope == ONE, ##1 (out_valid && out_pixel_color == $past(wt_tex_cliff, 2)), "full slope not cliff")

endmodule
